[hw/rtl/printer_line_capture_port_unit_defines.svh]
// Assertion macros shared by the printer line capture checker.
`ifndef PRINTER_LINE_CAPTURE_PORT_UNIT_DEFINES_SVH
`define PRINTER_LINE_CAPTURE_PORT_UNIT_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define PLCP_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("plcp same-cycle check failed");

// Next-cycle implication under synchronous reset.
`define PLCP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("plcp next-cycle check failed");

`endif

[hw/rtl/plcp_pkg.sv]
// Types and constants for the printer line capture port.
package plcp_pkg;

  localparam int LINE_BYTES_DEF = 32;
  localparam int IDX_W          = 5;   // line store index, up to 32 entries
  localparam int FILL_W         = 6;   // fill position, holds the line length
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;

  localparam logic [2:0] MODE_NONE       = 3'd0;
  localparam logic [2:0] MODE_EPSON      = 3'd1;
  localparam logic [2:0] MODE_EPSON_WIDE = 3'd2;
  localparam logic [2:0] MODE_HP         = 3'd3;
  localparam logic [2:0] MODE_HP_WIDE    = 3'd4;
  localparam logic [2:0] MODE_MAX        = MODE_HP_WIDE;

  localparam logic [7:0] STATUS_BASE     = 8'h3e;
  localparam logic [7:0] STATUS_NO_PRN   = 8'h40;
  localparam logic [7:0] STATUS_ONLINE   = 8'h01;
  localparam logic [7:0] BIT_BUSY        = 8'h80;
  localparam logic [7:0] BIT_STOP        = 8'h04;
  localparam logic [7:0] BIT_LINE_END    = 8'h02;
  localparam logic [3:0] GATHER_BITS     = 4'd8;
  localparam logic [3:0] ROW_LIMIT       = 4'd8;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_GATHER = 2'd1,
    OP_LINE   = 2'd2
  } op_kind_t;

  // One request handed from the front to the back.
  typedef struct packed {
    op_kind_t         kind;
    logic             wr_en;   // write the line store entry
    logic             or_en;   // merge with the entry instead of overwrite
    logic             flush;   // read the line out after the write
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [2:0]       mode;
    logic [3:0]       rows;
    logic [31:0]      tick;
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  mode;
    logic [3:0]  rows;
    logic [31:0] tick;
    logic [6:0]  len;
    logic        last;
  } res_t;

endpackage

[hw/rtl/plcp_front.sv]
// Front end: accepts port requests, tracks motor/row/gather state, issues store ops.
module plcp_front
  import plcp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_clear,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  input  logic [31:0] tick_stamp,
  input  logic        q_full,
  output logic        push,
  output op_t         push_op
);

  localparam logic [FILL_W-1:0] FILL_RESET = FILL_W'(LINE_BYTES);

  logic [2:0]        mode;
  logic [FILL_W-1:0] fill, fill_next;
  logic [3:0]        row, row_next;
  logic              motor, motor_next;
  logic [7:0]        last_written, last_written_next;
  logic [7:0]        gather, gather_next;
  logic [3:0]        gathered, gathered_next;

  logic              accept;
  logic              op_valid;
  logic [7:0]        pixel, rotated;
  logic [15:0]       doubled;
  logic [FILL_W-1:0] idx;
  logic [3:0]        row_adv;
  logic [7:0]        gather_shift;
  logic [3:0]        gathered_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && op_valid;

  always_comb begin
    pixel        = (mode == MODE_EPSON_WIDE) ? ((data_byte >> 1) | data_byte) : data_byte;
    doubled      = {pixel, pixel} >> row[2:0];
    rotated      = doubled[7:0];
    idx          = fill - FILL_W'(1);
    row_adv      = row + {1'b0, mode};
    gather_shift = {gather[6:0], data_byte[7]};
    gathered_inc = gathered + 4'd1;
  end

  always_comb begin
    fill_next         = fill;
    row_next          = row;
    motor_next        = motor;
    last_written_next = last_written;
    gather_next       = gather;
    gathered_next     = gathered;
    op_valid          = 1'b0;
    push_op           = '0;
    push_op.kind      = OP_STATUS;
    push_op.mode      = mode;
    push_op.rows      = row;
    push_op.tick      = tick_stamp;
    if (accept) begin
      if (command) begin
        op_valid     = 1'b1;
        push_op.mode = MODE_NONE;
        push_op.rows = 4'd0;
        push_op.tick = 32'd0;
        if (mode == MODE_NONE) begin
          push_op.data = STATUS_BASE | STATUS_NO_PRN;
        end else begin
          push_op.data = STATUS_BASE | STATUS_ONLINE | (last_written & BIT_BUSY);
        end
      end else begin
        last_written_next = data_byte;
        if ((data_byte & BIT_STOP) != 8'd0) begin
          if (motor) begin
            if (mode >= MODE_HP) begin
              if (gathered != 4'd0) begin
                op_valid      = 1'b1;
                push_op.kind  = OP_GATHER;
                push_op.data  = gather;
                gather_next   = 8'd0;
                gathered_next = 4'd0;
              end
            end else if (fill != FILL_RESET) begin
              // partial line: store and row cleared, fill position kept
              op_valid      = 1'b1;
              push_op.kind  = OP_LINE;
              push_op.flush = 1'b1;
              row_next      = 4'd0;
            end
            motor_next = 1'b0;
          end
        end else if (mode == MODE_NONE) begin
          // only the last written byte is recorded
        end else if (!motor) begin
          motor_next = 1'b1;
        end else if (mode >= MODE_HP) begin
          if (gathered_inc == GATHER_BITS) begin
            op_valid      = 1'b1;
            push_op.kind  = OP_GATHER;
            push_op.data  = gather_shift;
            gather_next   = 8'd0;
            gathered_next = 4'd0;
          end else begin
            gather_next   = gather_shift;
            gathered_next = gathered_inc;
          end
        end else begin
          op_valid      = 1'b1;
          push_op.kind  = OP_LINE;
          push_op.wr_en = 1'b1;
          push_op.or_en = (row != 4'd0);
          push_op.idx   = idx[IDX_W-1:0];
          push_op.data  = rotated;
          if (idx == '0) begin
            fill_next  = FILL_RESET;
            motor_next = 1'b0;
            if (((data_byte & BIT_LINE_END) != 8'd0) || (row_adv >= ROW_LIMIT)) begin
              push_op.flush = 1'b1;
              push_op.rows  = row_adv;
              row_next      = 4'd0;
            end else begin
              row_next = row_adv;
            end
          end else begin
            fill_next = idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      mode         <= rst ? MODE_NONE : cfg_wdata;
      fill         <= FILL_RESET;
      row          <= 4'd0;
      motor        <= 1'b0;
      last_written <= 8'd0;
      gather       <= 8'd0;
      gathered     <= 4'd0;
    end else begin
      fill         <= fill_next;
      row          <= row_next;
      motor        <= motor_next;
      last_written <= last_written_next;
      gather       <= gather_next;
      gathered     <= gathered_next;
    end
  end

endmodule

[hw/rtl/plcp_queue.sv]
// Short request queue between front and back.
module plcp_queue
  import plcp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head_op,
  output logic empty,
  output logic full
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty   = (count == '0);
  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

[hw/rtl/plcp_back.sv]
// Back end: line store, line readout sequencer and output register.
module plcp_back
  import plcp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_clear,
  input  op_t  head_op,
  input  logic q_empty,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_BYTES - 1);

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_FLUSH = 2'b10
  } back_state_t;

  back_state_t           state;
  logic [7:0]            store [LINE_BYTES];
  logic [LINE_BYTES-1:0] filled;
  logic [IDX_W-1:0]      cnt;
  logic                  second_pass;
  logic                  wide;
  logic [2:0]            run_mode;
  logic [3:0]            run_rows;
  logic [31:0]           run_tick;

  logic             can_load;
  logic             take;
  logic             store_wr;
  logic             start_flush;
  logic             run_last;
  logic             load_single;
  logic             load_run;
  logic [IDX_W-1:0] rd_idx;
  logic [AW-1:0]    ra;
  logic [7:0]       rd_byte;
  logic [7:0]       wr_byte;
  logic [6:0]       run_len;

  assign can_load    = !out_valid || out_ready;
  assign take        = (state == BK_IDLE) && !q_empty;
  assign pop         = take && ((head_op.kind == OP_LINE) || can_load);
  assign store_wr    = take && (head_op.kind == OP_LINE) && head_op.wr_en;
  assign start_flush = take && (head_op.kind == OP_LINE) && head_op.flush;
  assign load_single = pop && (head_op.kind != OP_LINE);
  assign load_run    = (state == BK_FLUSH) && can_load;

  // one read port: readout counter while flushing, else the merge target
  assign rd_idx   = (state == BK_FLUSH) ? cnt : head_op.idx;
  assign ra       = rd_idx[AW-1:0];
  assign rd_byte  = filled[ra] ? store[ra] : 8'h00;
  assign wr_byte  = (head_op.or_en ? rd_byte : 8'h00) | head_op.data;
  assign run_len  = wide ? 7'(2 * LINE_BYTES) : 7'(LINE_BYTES);
  assign run_last = (cnt == LAST_IDX) && (second_pass || !wide);

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[ra] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (start_flush) begin
      wide     <= (head_op.mode == MODE_EPSON_WIDE);
      run_mode <= head_op.mode;
      run_rows <= head_op.rows;
      run_tick <= head_op.tick;
    end
    if (load_single) begin
      res.kind <= (head_op.kind == OP_GATHER);
      res.data <= head_op.data;
      res.mode <= head_op.mode;
      res.rows <= head_op.rows;
      res.tick <= head_op.tick;
      res.len  <= (head_op.kind == OP_GATHER) ? 7'd1 : 7'd0;
      res.last <= (head_op.kind == OP_GATHER);
    end else if (load_run) begin
      res.kind <= 1'b1;
      res.data <= rd_byte;
      res.mode <= run_mode;
      res.rows <= run_rows;
      res.tick <= run_tick;
      res.len  <= run_len;
      res.last <= run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      filled      <= '0;
      cnt         <= '0;
      second_pass <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (load_single || load_run) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_clear) begin
        filled <= '0;
      end else if (store_wr) begin
        filled[ra] <= 1'b1;
      end
      unique case (state)
        BK_IDLE: begin
          if (start_flush) begin
            state       <= BK_FLUSH;
            cnt         <= '0;
            second_pass <= 1'b0;
          end
        end
        BK_FLUSH: begin
          if (load_run) begin
            if (run_last) begin
              state  <= BK_IDLE;
              filled <= '0;
            end else if (cnt == LAST_IDX) begin
              cnt         <= '0;
              second_pass <= 1'b1;
            end else begin
              cnt <= cnt + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/printer_line_capture_port_unit.sv]
// Printer line capture port: top level joining front end, request queue and back end.
// Takes one port request per cycle while the 4-entry request queue has room. A status read
// or a completed 8-bit HP gather gives one registered result. A line flush streams the
// line store out at one byte per cycle while out_ready is high, from a single read port:
// LINE_BYTES results, or 2*LINE_BYTES in Epson enlarged mode, and the queue fills behind
// it while that runs. The store is cleared through per-entry valid flags, so reset needs
// no clearing pass. Mode writes above 4 are ignored; others reset the front end and store.
module printer_line_capture_port_unit
  import plcp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  data_byte,
  input  logic [31:0] tick_stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  out_byte,
  output logic [2:0]  flush_mode,
  output logic [3:0]  flush_rows,
  output logic [31:0] flush_tick,
  output logic [6:0]  flush_length,
  output logic        last_of_run
);

  logic cfg_clear;
  logic push, pop, q_empty, q_full;
  op_t  push_op, head_op;
  res_t res;

  assign cfg_clear = cfg_we && (cfg_wdata <= MODE_MAX);

  plcp_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_clear),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .data_byte  (data_byte),
    .tick_stamp (tick_stamp),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  plcp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  plcp_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_clear),
    .head_op   (head_op),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign result_kind  = res.kind;
  assign out_byte     = res.data;
  assign flush_mode   = res.mode;
  assign flush_rows   = res.rows;
  assign flush_tick   = res.tick;
  assign flush_length = res.len;
  assign last_of_run  = res.last;

endmodule

[hw/rtl/plcp_checker.sv]
// Port-level checks for the printer line capture port, bound to the top level.
`include "printer_line_capture_port_unit_defines.svh"

module plcp_checker
  import plcp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [7:0]  out_byte,
  input logic [2:0]  flush_mode,
  input logic [3:0]  flush_rows,
  input logic [31:0] flush_tick,
  input logic [6:0]  flush_length,
  input logic        last_of_run
);

  // status results carry no run information
  `PLCP_ASSERT_NOW(a_status_clean, clk, rst, out_valid && !result_kind,
    flush_length == 7'd0 && !last_of_run && flush_tick == 32'd0 &&
    flush_mode == 3'd0 && flush_rows == 4'd0)

  // a run is one gathered byte, one line, or a doubled line
  `PLCP_ASSERT_NOW(a_run_length, clk, rst, out_valid && result_kind,
    flush_length == 7'd1 || flush_length == 7'(LINE_BYTES) || flush_length == 7'(2 * LINE_BYTES))

  // a line run streams without gaps and keeps its header
  `PLCP_ASSERT_NEXT(a_run_streams, clk, rst, out_valid && out_ready && result_kind && !last_of_run,
    out_valid && result_kind && flush_length == $past(flush_length) &&
    flush_tick == $past(flush_tick))

  `PLCP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_byte) && $stable(result_kind))

endmodule

bind printer_line_capture_port_unit plcp_checker #(.LINE_BYTES(LINE_BYTES)) u_plcp_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the printer line capture port: random traffic vs a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import plcp_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int LINE_LEN    = LINE_BYTES_DEF;
  localparam int IDLE_PCT    = 27;
  localparam int RAND_ITEMS  = 370;
  localparam int PHASE_ITEMS = 30;
  localparam int SETTLE      = 16;   // request queue depth plus pipeline
  localparam int END_WAIT    = 100;
  localparam int STALL_LIMIT = 2000;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_STATUS  = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_LINE   = 1'b1;
  localparam logic [2:0] MODE_BAD = 3'd7;
  // eight HP writes, bit 7 of each one is gathered
  localparam logic [63:0] HP_PATTERN = 64'h80_00_fb_7b_80_80_00_f8;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic [31:0] tick;
  } port_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  mode;
    logic [3:0]  rows;
    logic [31:0] tick;
    logic [6:0]  len;
    logic        last;
  } line_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  data_byte = '0;
  logic [31:0] tick_stamp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  out_byte;
  logic [2:0]  flush_mode;
  logic [3:0]  flush_rows;
  logic [31:0] flush_tick;
  logic [6:0]  flush_length;
  logic        last_of_run;

  printer_line_capture_port_unit #(
    .LINE_BYTES(LINE_LEN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .data_byte(data_byte),
    .tick_stamp(tick_stamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .out_byte(out_byte),
    .flush_mode(flush_mode),
    .flush_rows(flush_rows),
    .flush_tick(flush_tick),
    .flush_length(flush_length),
    .last_of_run(last_of_run)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // printer state as the block should hold it
  logic [2:0] prn_mode;
  logic [7:0] line_buf [LINE_LEN];
  logic [5:0] fill_pos;
  logic [3:0] row_pos;
  logic       motor_run;
  logic [7:0] last_byte;
  logic [7:0] hp_byte;
  logic [3:0] hp_count;

  port_req_t pending_reqs[$];
  line_res_t due_results[$];
  int        reqs_queued = 0;
  int        reqs_taken = 0;
  int        pushed = 0;
  int        fail_cnt = 0;
  int        stall_cycles = 0;
  int        in_idle_pct = IDLE_PCT;
  int        out_idle_pct = IDLE_PCT;
  port_req_t next_req;
  line_res_t got;
  line_res_t want;

  function automatic void clear_printer();
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    fill_pos  = 6'(LINE_LEN);
    row_pos   = '0;
    motor_run = 1'b0;
    last_byte = '0;
    hp_byte   = '0;
    hp_count  = '0;
  endfunction

  function automatic void set_mode(input logic [2:0] v);
    if (v > MODE_MAX) return;
    clear_printer();
    prn_mode = v;
  endfunction

  function automatic void queue_line_byte(input logic [7:0] b, input logic [6:0] len,
                                          input logic [31:0] tick, input logic last);
    line_res_t r;
    r.kind = KIND_LINE;
    r.data = b;
    r.mode = prn_mode;
    r.rows = row_pos;
    r.tick = tick;
    r.len  = len;
    r.last = last;
    due_results.push_back(r);
  endfunction

  function automatic void dump_line(input logic [31:0] tick);
    int len;
    len = (prn_mode == MODE_EPSON_WIDE) ? 2 * LINE_LEN : LINE_LEN;
    for (int k = 0; k < len; k++)
      queue_line_byte(line_buf[k % LINE_LEN], 7'(len), tick, k == len - 1);
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    row_pos = '0;
  endfunction

  function automatic void dump_gather(input logic [31:0] tick);
    queue_line_byte(hp_byte, 7'd1, tick, 1'b1);
    hp_byte  = '0;
    hp_count = '0;
  endfunction

  function automatic void epson_pixel(input logic [7:0] d, input logic [31:0] tick);
    logic [7:0]  pix;
    logic [15:0] twice;
    logic [5:0]  idx;
    pix = d;
    if (prn_mode == MODE_EPSON_WIDE) pix = pix | (pix >> 1);
    if (fill_pos == 0 || fill_pos > LINE_LEN) return;
    idx = fill_pos - 6'd1;
    if (row_pos != 0) begin
      // rotate right by the row offset, then merge
      twice = {pix, pix} >> row_pos[2:0];
      line_buf[idx] = line_buf[idx] | twice[7:0];
    end else begin
      line_buf[idx] = pix;
    end
    fill_pos = idx;
    if (fill_pos == 0) begin
      fill_pos  = 6'(LINE_LEN);
      row_pos   = row_pos + 4'(prn_mode);
      motor_run = 1'b0;
      if ((last_byte & BIT_LINE_END) != 0 || row_pos >= ROW_LIMIT) dump_line(tick);
    end
  endfunction

  function automatic void port_response(input logic cmd, input logic [7:0] d,
                                        input logic [31:0] tick);
    line_res_t r;
    if (cmd == CMD_STATUS) begin
      r = '0;
      r.kind = KIND_STATUS;
      r.data = (prn_mode == MODE_NONE) ? (STATUS_BASE | STATUS_NO_PRN)
                                       : (STATUS_BASE | STATUS_ONLINE | (last_byte & BIT_BUSY));
      due_results.push_back(r);
      return;
    end
    last_byte = d;
    if ((d & BIT_STOP) != 0) begin
      if (motor_run) begin
        if (prn_mode >= MODE_HP) begin
          if (hp_count != 0) dump_gather(tick);
        end else if (fill_pos != LINE_LEN) begin
          dump_line(tick);
        end
        motor_run = 1'b0;
      end
      return;
    end
    if (prn_mode == MODE_NONE) return;
    if (!motor_run) begin
      motor_run = 1'b1;
      return;
    end
    if (prn_mode >= MODE_HP) begin
      hp_byte  = {hp_byte[6:0], d[7]};
      hp_count = hp_count + 4'd1;
      if (hp_count == GATHER_BITS) dump_gather(tick);
      return;
    end
    epson_pixel(d, tick);
  endfunction

  function automatic string show(input line_res_t r);
    return $sformatf("kind=%0d byte=%h mode=%0d rows=%0d tick=%h len=%0d last=%0d",
                     r.kind, r.data, r.mode, r.rows, r.tick, r.len, r.last);
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  // driver: one request in flight, held until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        port_response(command, data_byte, tick_stamp);
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid   <= 1'b1;
          command    <= next_req.cmd;
          data_byte  <= next_req.data;
          tick_stamp <= next_req.tick;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {result_kind, out_byte, flush_mode, flush_rows, flush_tick, flush_length,
               last_of_run};
        if (due_results.size() == 0) begin
          note_failure($sformatf("unexpected result: %s", show(got)));
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.mode !== want.mode ||
              got.rows !== want.rows || got.tick !== want.tick || got.len !== want.len ||
              got.last !== want.last)
            note_failure($sformatf("result mismatch: expected %s, got %s",
                                   show(want), show(got)));
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (reqs_taken == reqs_queued && due_results.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_tick();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom();
  endfunction

  function automatic logic [7:0] pixel_byte();
    logic [7:0] d;
    d = 8'($urandom_range(255));
    return d & ~BIT_STOP;
  endfunction

  task automatic push_req(input logic cmd, input logic [7:0] d, input logic [31:0] tick);
    port_req_t r;
    r.cmd  = cmd;
    r.data = d;
    r.tick = tick;
    pending_reqs.push_back(r);
    reqs_queued++;
    pushed++;
  endtask

  // a write, now and then preceded by a status read
  task automatic push_write(input logic [7:0] d);
    if ($urandom_range(99) < 6) push_req(CMD_STATUS, 8'($urandom_range(255)), rand_tick());
    push_req(CMD_WRITE, d, rand_tick());
  endtask

  task automatic epson_line(input bit line_end);
    logic [7:0] d;
    push_write(pixel_byte());
    for (int i = 0; i < LINE_LEN; i++) begin
      d = pixel_byte();
      if (i == LINE_LEN - 1) d = line_end ? (d | BIT_LINE_END) : (d & ~BIT_LINE_END);
      push_write(d);
    end
  endtask

  task automatic add_job(input logic [2:0] m);
    int pick;
    int n;
    pick = $urandom_range(99);
    if ((m == MODE_EPSON || m == MODE_EPSON_WIDE) && pick < 45) begin
      epson_line(pick < 25);
    end else if (m != MODE_NONE && pick < 80) begin
      // partial line or partial gather; epson always ends on a stop, HP half the time
      push_write(pixel_byte());
      n = (m >= MODE_HP) ? $urandom_range(20, 1) : $urandom_range(LINE_LEN - 1);
      repeat (n) push_write(pixel_byte());
      if (m < MODE_HP || $urandom_range(1) == 1) push_write(pixel_byte() | BIT_STOP);
    end else begin
      repeat ($urandom_range(4, 1))
        push_req(1'($urandom_range(1)), 8'($urandom_range(255)), rand_tick());
    end
  endtask

  task automatic wait_idle();
    while (reqs_taken != reqs_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic [2:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_mode(v);
  endtask

  initial begin
    int phase_start;
    logic [2:0] m;
    set_mode(MODE_NONE);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: no printer
    write_mode(MODE_NONE);
    push_req(CMD_STATUS, 8'h00, 32'h0);
    push_req(CMD_WRITE, 8'hff, 32'hffff_ffff);
    push_req(CMD_STATUS, 8'hff, 32'h0);
    push_req(CMD_WRITE, 8'h00, 32'h1);
    push_req(CMD_STATUS, 8'h5a, rand_tick());
    // directed: HP enlarged, full gather then a partial one cut by a stop
    write_mode(MODE_HP_WIDE);
    push_req(CMD_STATUS, 8'h00, 32'h0);
    push_req(CMD_WRITE, 8'h00, 32'h2);
    for (int i = 7; i >= 0; i--) push_req(CMD_WRITE, HP_PATTERN[i*8 +: 8], rand_tick());
    push_req(CMD_STATUS, 8'h00, rand_tick());
    push_req(CMD_WRITE, 8'h80, rand_tick());
    push_req(CMD_WRITE, 8'h84, 32'hffff_ffff);
    push_req(CMD_WRITE, BIT_STOP, rand_tick());
    // directed: epson, two pixels then a partial-line flush
    write_mode(MODE_EPSON);
    push_req(CMD_WRITE, 8'h00, rand_tick());
    push_req(CMD_WRITE, 8'hfb, rand_tick());
    push_req(CMD_WRITE, 8'h01, rand_tick());
    push_req(CMD_WRITE, 8'hff, 32'hffff_ffff);

    pushed = 0;
    for (int p = 0; p < 5 || pushed < RAND_ITEMS; p++) begin
      case (p)
        0:       m = MODE_EPSON;
        1:       m = MODE_EPSON_WIDE;
        2:       m = MODE_HP;
        3:       m = MODE_HP_WIDE;
        4:       m = MODE_NONE;
        default: m = 3'($urandom_range(MODE_MAX));
      endcase
      write_mode(m);
      in_idle_pct  = (p == 3) ? 0 : IDLE_PCT;
      out_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      // fresh state: full lines until the row offset reaches eight
      if (p == 1) repeat (ROW_LIMIT / m) epson_line(1'b0);
      phase_start = pushed;
      while (pushed - phase_start < PHASE_ITEMS) add_job(m);
      if (p == 1) begin
        // out-of-range mode must leave state intact
        write_mode(MODE_BAD);
        phase_start = pushed;
        while (pushed - phase_start < PHASE_ITEMS) add_job(m);
      end
    end

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/plcp_pkg.sv
hw/rtl/plcp_front.sv
hw/rtl/plcp_queue.sv
hw/rtl/plcp_back.sv
hw/rtl/printer_line_capture_port_unit.sv
hw/rtl/plcp_checker.sv
tb/tb_top.sv
